// ===== design/mf3b_pkg.sv =====
// Shared types and constants for the 3x3 border-aware median filter.
// Used by every module of the block; it depends on nothing else.
package mf3b_pkg;

    localparam int PIXEL_W       = 8;
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int CFG_W         = 13;
    localparam int WIN_N         = 9;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // One result to be produced from the window: which taps take part,
    // the sorted rank to pick, and the end-of-frame mark.
    typedef struct packed {
        logic [WIN_N-1:0] mask;
        logic [2:0]       target;
        logic             frame_end;
    } res_desc_t;

    typedef struct packed {
        res_desc_t [3:0] desc;
        logic [2:0]      count;
    } job_t;

    // Position of a pixel relative to the image borders.
    typedef struct packed {
        logic c_ge1;
        logic c_ge2;
        logic c_last;
        logic r_ge1;
        logic r_ge2;
        logic r_last;
    } pos_t;

endpackage

// ===== design/mf3b_line_store.sv =====
// Synchronous dual-row line store: one write and one read port, read data
// registered. Holds the older row in the upper byte, the newer in the lower.
module mf3b_line_store
    import mf3b_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
)
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [2*PIXEL_W-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [2*PIXEL_W-1:0] wr_data
);

    logic [2*PIXEL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/mf3b_window.sv =====
// 3x3 window registers and the planning of the results each pixel causes.
// Depends on mf3b_pkg for the descriptor and position types.
module mf3b_window
    import mf3b_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     item_valid,
    input  logic [PIXEL_W-1:0]       above2,
    input  logic [PIXEL_W-1:0]       above1,
    input  logic [PIXEL_W-1:0]       pixel,
    input  pos_t                     pos,
    output logic [WIN_N*PIXEL_W-1:0] win_next,
    output job_t                     job
);

    logic [WIN_N*PIXEL_W-1:0] win_reg;

    function automatic logic [WIN_N-1:0] make_mask(input logic [2:0] rows,
                                                   input logic [2:0] cols);
        logic [WIN_N-1:0] m;
        m = '0;
        for (int wr = 0; wr < 3; wr++)
        begin
            for (int wc = 0; wc < 3; wc++)
            begin
                m[wr*3+wc] = rows[wr] & cols[wc];
            end
        end
        return m;
    endfunction

    function automatic logic [2:0] mid_rank(input logic [WIN_N-1:0] m);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            n = n + {3'd0, m[i]};
        end
        return 3'((n - 4'd1) >> 1);
    endfunction

    // Window rows: 0 is two rows up, 1 the row above, 2 the incoming row.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[(k*3+0)*PIXEL_W +: PIXEL_W] = win_reg[(k*3+1)*PIXEL_W +: PIXEL_W];
            win_next[(k*3+1)*PIXEL_W +: PIXEL_W] = win_reg[(k*3+2)*PIXEL_W +: PIXEL_W];
        end
        win_next[2*PIXEL_W +: PIXEL_W] = above2;
        win_next[5*PIXEL_W +: PIXEL_W] = above1;
        win_next[8*PIXEL_W +: PIXEL_W] = pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (step && item_valid)
        begin
            win_reg <= win_next;
        end
    end

    // Results come in column order; on the last row each result of the row
    // above is followed by the one for the same column of the last row.
    always_comb
    begin
        logic [2:0]  rows_up;
        logic [2:0]  rows_cur;
        logic [2:0]  cols_prev;
        logic [2:0]  cols_this;
        res_desc_t   d;
        job_t        j;
        rows_up   = {1'b1, 1'b1, pos.r_ge2};
        rows_cur  = {1'b1, pos.r_ge1, 1'b0};
        cols_prev = {1'b1, 1'b1, pos.c_ge2};
        cols_this = {1'b1, pos.c_ge1, 1'b0};
        d = '0;
        j = '0;
        if (item_valid && pos.c_ge1)
        begin
            if (pos.r_ge1)
            begin
                d.mask = make_mask(rows_up, cols_prev);
                d.target = mid_rank(d.mask);
                d.frame_end = 1'b0;
                j.desc[j.count[1:0]] = d;
                j.count = j.count + 3'd1;
            end
            if (pos.r_last)
            begin
                d.mask = make_mask(rows_cur, cols_prev);
                d.target = mid_rank(d.mask);
                d.frame_end = 1'b0;
                j.desc[j.count[1:0]] = d;
                j.count = j.count + 3'd1;
            end
        end
        if (item_valid && pos.c_last)
        begin
            if (pos.r_ge1)
            begin
                d.mask = make_mask(rows_up, cols_this);
                d.target = mid_rank(d.mask);
                d.frame_end = 1'b0;
                j.desc[j.count[1:0]] = d;
                j.count = j.count + 3'd1;
            end
            if (pos.r_last)
            begin
                d.mask = make_mask(rows_cur, cols_this);
                d.target = mid_rank(d.mask);
                d.frame_end = 1'b1;
                j.desc[j.count[1:0]] = d;
                j.count = j.count + 3'd1;
            end
        end
        job = j;
    end

endmodule

// ===== design/mf3b_select.sv =====
// Rank selection and result serialiser with its output register.
// Depends on mf3b_pkg; fed by mf3b_window with a window and a job.
module mf3b_select
    import mf3b_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  job_t                     job,
    input  logic [WIN_N*PIXEL_W-1:0] win,
    output logic                     step,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [PIXEL_W-1:0]       m_tdata,
    output logic                     m_tlast,
    output logic [0:0]               m_tuser
);

    res_desc_t [3:0]          desc_reg;
    logic [2:0]               count_reg;
    logic [1:0]               idx_reg;
    logic [WIN_N*PIXEL_W-1:0] vals_reg;
    logic [WIN_N*WIN_N-1:0]   below_reg;
    logic [WIN_N*WIN_N-1:0]   below_next;
    logic                     m_valid_reg;
    logic [PIXEL_W-1:0]       m_data_reg;
    logic                     m_last_reg;
    logic                     m_fe_reg;
    logic                     busy;
    logic                     is_last;
    logic                     emit;
    res_desc_t                cur;
    logic [PIXEL_W-1:0]       pick_val;

    // below[i*9+j]: tap j sorts before tap i, ties broken by tap index.
    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            for (int j = 0; j < WIN_N; j++)
            begin
                below_next[i*WIN_N+j] =
                    (win[j*PIXEL_W +: PIXEL_W] < win[i*PIXEL_W +: PIXEL_W]) ||
                    ((win[j*PIXEL_W +: PIXEL_W] == win[i*PIXEL_W +: PIXEL_W]) && (j < i));
            end
        end
    end

    assign busy    = (count_reg != 3'd0);
    assign is_last = ({1'b0, idx_reg} == (count_reg - 3'd1));
    assign emit    = busy && (!m_valid_reg || m_tready);
    assign step    = !busy || (emit && is_last);
    assign cur     = desc_reg[idx_reg];

    always_comb
    begin
        logic [3:0] rank;
        pick_val = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            rank = '0;
            for (int j = 0; j < WIN_N; j++)
            begin
                rank = rank + {3'd0, cur.mask[j] & below_reg[i*WIN_N+j]};
            end
            if (cur.mask[i] && (rank == {1'b0, cur.target}))
            begin
                pick_val = pick_val | vals_reg[i*PIXEL_W +: PIXEL_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (step)
        begin
            count_reg <= job.count;
            idx_reg   <= '0;
        end
        else if (emit)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            desc_reg  <= job.desc;
            vals_reg  <= win;
            below_reg <= below_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_data_reg <= pick_val;
            m_last_reg <= is_last;
            m_fe_reg   <= cur.frame_end;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_fe_reg;

endmodule

// ===== design/median_filter_3x3_border_top.sv =====
// Top level of the 3x3 border-aware median filter: counters, line store
// access with forwarding, and the stage registers. Uses mf3b_pkg and all submodules.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] pixel_value
//  m_      | out | m_tvalid/m_tready  | m_tdata[7:0] filtered_value, m_tlast last_of_run,
//          |     |                    | m_tuser[0] frame_end
//  cfg_    | in  | cfg_we             | cfg_addr register index, cfg_data[12:0]
//
// One pixel is taken per cycle while the output serialiser is not busy; the line
// store is read in the accept cycle and written back as the pixel leaves the stage registers.
// On the last row a pixel causes up to four results, one per cycle from the
// output serialiser while m_tready holds, and input is held while they go out.
// Reset is asynchronous and needs no clearing pass; line store contents are
// undefined until written. A stall on m_ holds the whole pipeline.
module median_filter_3x3_border_top
    import mf3b_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIXEL_W-1:0] s_tdata,   // [7:0] pixel_value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [PIXEL_W-1:0] m_tdata,   // [7:0] filtered_value
    output logic               m_tlast,
    output logic [0:0]         m_tuser,   // [0] frame_end
    input  logic               cfg_we,
    input  logic [0:0]         cfg_addr,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [AW-1:0]        col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [AW-1:0]        wlast;
    logic [ROW_W-1:0]     hlast;

    logic                 s1_valid_reg;
    logic [PIXEL_W-1:0]   s1_pix_reg;
    logic [AW-1:0]        s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic                 fwd_hit_reg;
    logic [2*PIXEL_W-1:0] fwd_data_reg;

    logic                 step;
    logic                 accept;
    logic [2*PIXEL_W-1:0] rd_data;
    logic [2*PIXEL_W-1:0] col_data;
    logic [2*PIXEL_W-1:0] wr_data;
    pos_t                 pos;
    job_t                 job;
    logic [WIN_N*PIXEL_W-1:0] win_next;

    always_comb
    begin
        if (width_reg == '0)
            wlast = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            wlast = AW'(MAX_WIDTH - 1);
        else
            wlast = AW'(width_reg - 1'b1);
        if (height_reg == '0)
            hlast = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            hlast = ROW_W'(MAX_HEIGHT - 1);
        else
            hlast = ROW_W'(height_reg - 1'b1);
    end

    assign s_tready = step;
    assign accept   = s_tvalid && step;

    // Any register write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == wlast)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == hlast) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (step)
        begin
            s1_valid_reg <= s_tvalid;
            if (s_tvalid)
                fwd_hit_reg <= s1_valid_reg && (s1_col_reg == col_reg);
        end
    end

    // A read that meets the write-back to the same column in the same cycle
    // takes the written value from here instead of the memory.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= s_tdata;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            fwd_data_reg <= wr_data;
        end
    end

    assign col_data = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_data  = {col_data[PIXEL_W-1:0], s1_pix_reg};

    assign pos.c_ge1  = (s1_col_reg != '0);
    assign pos.c_ge2  = (s1_col_reg > AW'(1));
    assign pos.c_last = (s1_col_reg == wlast);
    assign pos.r_ge1  = (s1_row_reg != '0);
    assign pos.r_ge2  = (s1_row_reg > ROW_W'(1));
    assign pos.r_last = (s1_row_reg == hlast);

    mf3b_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (step && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    mf3b_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item_valid (s1_valid_reg),
        .above2     (col_data[2*PIXEL_W-1:PIXEL_W]),
        .above1     (col_data[PIXEL_W-1:0]),
        .pixel      (s1_pix_reg),
        .pos        (pos),
        .win_next   (win_next),
        .job        (job)
    );

    mf3b_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .win      (win_next),
        .step     (step),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/sv/median_filter_3x3_border_checker.sv =====
// Checker for the 3x3 border-aware median filter: follows pixel, result and
// register transfers, predicts each filtered pixel and compares it field by field.
// Depends on mf3b_pkg for widths and register indexes.
`timescale 1ns / 1ps

module median_filter_3x3_border_checker
    import mf3b_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [PIXEL_W-1:0] s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [PIXEL_W-1:0] m_tdata,
    input  logic               m_tlast,
    input  logic [0:0]         m_tuser,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_addr,
    input  logic [CFG_W-1:0]   cfg_data,
    output int                 pending,
    output int                 fail_count
);

    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic               last;
        logic               frame_end;
    } filtered_t;

    filtered_t          expected_pixels[$];
    logic [PIXEL_W-1:0] row_older[DEF_MAX_WIDTH];
    logic [PIXEL_W-1:0] row_newer[DEF_MAX_WIDTH];
    logic [PIXEL_W-1:0] window[WIN_N];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    int                 col_pos;
    int                 row_pos;

    initial
    begin
        width_reg  = 13'd640;
        height_reg = 13'd480;
        col_pos    = 0;
        row_pos    = 0;
        fail_count = 0;
        pending    = 0;
        foreach (window[i])
            window[i] = '0;
        foreach (row_older[i])
        begin
            row_older[i] = '0;
            row_newer[i] = '0;
        end
    end

    // Window column 2 holds the current column, window row 2 the current row.
    function automatic logic [PIXEL_W-1:0] neighbourhood_median(int orow, int ocol,
                                                                int cr, int cc, int w, int h);
        logic [PIXEL_W-1:0] vals[9];
        logic [PIXEL_W-1:0] t;
        int n;
        int r0, r1, c0, c1, wr, wc, j;
        n  = 0;
        r0 = (orow - 1 < 0) ? 0 : orow - 1;
        r1 = (orow + 1 > h - 1) ? h - 1 : orow + 1;
        c0 = (ocol - 1 < 0) ? 0 : ocol - 1;
        c1 = (ocol + 1 > w - 1) ? w - 1 : ocol + 1;
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
            begin
                wr = r - cr + 2;
                wc = c - cc + 2;
                if (wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2 && n < 9)
                begin
                    vals[n] = window[wr * 3 + wc];
                    n++;
                end
            end
        if (n == 0)
            return '0;
        for (int i = 1; i < n; i++)
        begin
            t = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > t)
            begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = t;
        end
        return vals[(n - 1) / 2];
    endfunction

    function automatic void filter_pixel(logic [PIXEL_W-1:0] pix);
        filtered_t res[4];
        int w, h, c, r, n, oc;
        w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        n = 0;
        for (int k = 0; k < 3; k++)
        begin
            window[k * 3 + 0] = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2]    = row_older[c];
        window[5]    = row_newer[c];
        window[8]    = pix;
        row_older[c] = row_newer[c];
        row_newer[c] = pix;
        for (int x = 0; x < 2; x++)
        begin
            if ((x == 0 && c >= 1) || (x == 1 && c == w - 1))
            begin
                oc = (x == 0) ? c - 1 : c;
                if (r >= 1 && n < 4)
                begin
                    res[n] = '{neighbourhood_median(r - 1, oc, r, c, w, h), 1'b0, 1'b0};
                    n++;
                end
                // On the last row the pixel of that row follows in the same column.
                if (r == h - 1 && n < 4)
                begin
                    res[n] = '{neighbourhood_median(r, oc, r, c, w, h), 1'b0, oc == w - 1};
                    n++;
                end
            end
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_pixels.push_back(res[i]);
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    always @(posedge clk)
    begin
        filtered_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result value=%0d last=%0b frame_end=%0b",
                                 $realtime, m_tdata, m_tlast, m_tuser[0]);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.value !== m_tdata || want.last !== m_tlast
                        || want.frame_end !== m_tuser[0])
                    begin
                        fail_count++;
                        // Fields are shown as value/last/frame_end.
                        if (fail_count <= 10)
                            $display("%0t: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, want.value, want.last, want.frame_end,
                                     m_tdata, m_tlast, m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                filter_pixel(s_tdata);
            if (cfg_we)
            begin
                if (cfg_addr == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                col_pos = 0;
                row_pos = 0;
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the 3x3 border-aware median filter: clock, reset, pixel
// stimulus, output back-pressure and verdict. Needs mf3b_pkg, the block and
// median_filter_3x3_border_checker.
`timescale 1ns / 1ps

module tb
    import mf3b_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [PIXEL_W-1:0] s_tdata;   // [7:0] pixel_value
    logic               m_tvalid;
    logic               m_tready;
    logic [PIXEL_W-1:0] m_tdata;   // [7:0] filtered_value
    logic               m_tlast;
    logic [0:0]         m_tuser;   // [0] frame_end
    logic               cfg_we;
    logic [0:0]         cfg_addr;
    logic [CFG_W-1:0]   cfg_data;
    int                 pending;
    int                 fail_count;

    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int hold_left;
    logic hold_go;
    logic hold_taken;
    int phase_no;
    int random_items;

    localparam int WATCHDOG_LIMIT = 5000;

    median_filter_3x3_border_top uut (.*);

    median_filter_3x3_border_checker checker_i (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off so that the pipeline fills.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_taken)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 300;
            hold_taken <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Counts cycles in which neither channel makes a transfer.
    always @(posedge clk)
    begin
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
        else
            idle_cycles = 0;
    end

    task automatic set_idling(int sel);
        case (sel % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    // Registers are written only once every result has left and the pipeline is empty.
    task automatic write_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_addr <= REG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_pixel(logic [PIXEL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // style 0: full random, 1: only the extreme values, 2: ramp with small noise
    task automatic run_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int count, int style);
        logic [PIXEL_W-1:0] v;
        write_geometry(w, h);
        set_idling(phase_no);
        phase_no++;
        for (int i = 0; i < count; i++)
        begin
            case (style)
                0: v = $urandom_range(255);
                1: v = $urandom_range(1) ? 8'hFF : 8'h00;
                default: v = 8'(i * 7 + $urandom_range(3));
            endcase
            send_pixel(v);
        end
    endtask

    initial
    begin
        int w, h, n;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_IMAGE_WIDTH;
        cfg_data       = '0;
        hold_go        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_cycles    = 0;
        phase_no       = 0;
        random_items   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: smallest frames, one-pixel sizes, out-of-range sizes.
        run_frame(13'd3, 13'd3, 9, 1);
        run_frame(13'd2, 13'd2, 4, 0);
        run_frame(13'd1, 13'd1, 3, 1);
        run_frame(13'd0, 13'd0, 2, 0);
        run_frame(13'd1, 13'd3, 3, 0);
        run_frame(13'd4, 13'd1, 4, 1);
        // Widths and heights above the maximum are capped; only the start of a row is sent.
        run_frame(13'h1FFF, 13'd1, 16, 0);
        run_frame(13'd4096, 13'h1FFF, 16, 2);

        // Random frames, mostly complete; some are cut short by a register write.
        while (random_items < 400)
        begin
            w = $urandom_range(12, 1);
            h = $urandom_range(8, 1);
            n = ($urandom_range(5) == 0) ? $urandom_range(w * h, 1) : w * h;
            if (random_items > 150 && !hold_go)
            begin
                hold_go <= 1'b1;
                w = 12;
                h = 8;
                n = w * h;
            end
            run_frame(w[CFG_W-1:0], h[CFG_W-1:0], n, $urandom_range(3) == 0 ? 1 : 0);
            random_items += n;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
